// ----- rtl/rrts_pkg.sv -----
// Shared types and codes for the round-robin task selector.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  // Operation codes carried in the request word.
  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_EXIT   = 3'd1,
    OP_WAIT   = 3'd2,
    OP_SLEEP  = 3'd3,
    OP_YIELD  = 3'd4
  } op_e;

  // Per-entry task status.
  typedef enum logic [1:0] {
    ST_EXITED   = 2'd0,
    ST_SLEEPING = 2'd1,
    ST_WAITING  = 2'd2,
    ST_READY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  target_task;
    logic [31:0] sleep_ms;
    logic [31:0] now_ms;
  } sel_in_t;

  typedef struct packed {
    logic [3:0] next_task;
    logic [3:0] new_handle;
    logic       none_ready;
    logic       table_full;
  } sel_out_t;

endpackage

`default_nettype wire

// ----- rtl/round_robin_task_selector_unit.sv -----
// Round-robin task selector: task table, sequencer and scan unit.
//
// Usage: the request channel (in_valid_i, in_stall_o, in_data_i) takes one
// word per operation: create, exit, wait, sleep or yield. The response
// channel (out_valid_o, out_stall_i, out_data_o) returns exactly one word
// per request, in order.
// Sequence: a create or an undefined code goes from the execute step
// straight to the finish step. A scheduling operation scans one entry
// per step, with an extra step for every waiting entry whose target must
// be looked up, then finishes. Each scan step uses the single read port
// on the status table, which the sequencer uses once per cycle. One
// request is in flight at a time; in_stall_o is high from accept until
// the result is loaded into the output register.
// Reset: all entries exited, one claimed entry, task 0 running.
// A stalled result holds in the output register; the next request may be
// accepted meanwhile, and its result waits until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_selector_unit
  import rrts_pkg::*;
#(
  parameter int TASK_SLOTS = 12,
  parameter int TIME_BITS  = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire sel_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output sel_out_t      out_data_o
);

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int TGT_W = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_TGT,
    S_FINISH
  } state_e;

  // Control state
  state_e               state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [IDX_W-1:0]     running_q, running_d;
  logic [CNT_W-1:0]     count_q, count_d;
  sel_out_t             res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  sel_out_t             out_q, out_d;
  status_e              status_q [TASK_SLOTS];

  // Payload state
  logic [2:0]           op_q;
  logic [3:0]           tgt_q;
  logic [TIME_BITS-1:0] ms_q, now_q;
  logic [TIME_BITS-1:0] wake_q [TASK_SLOTS];
  logic [3:0]           awaited_q [TASK_SLOTS];

  // Table write controls
  logic                 st_we;
  logic [IDX_W-1:0]     st_wa;
  status_e              st_wd;
  logic                 wk_we;
  logic [IDX_W-1:0]     wk_wa;
  logic [TIME_BITS-1:0] wk_wd;
  logic                 aw_we;
  logic [IDX_W-1:0]     aw_wa;
  logic [3:0]           aw_wd;

  // Shared status read port
  logic [IDX_W-1:0]     rd_addr;
  status_e              st_rd;
  logic                 tgt_oob;
  logic                 idx_last;
  logic [IDX_W-1:0]     idx_nxt;
  logic                 accept;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign rd_addr  = (state_q == S_TGT) ? IDX_W'(awaited_q[idx_q]) : idx_q;
  assign st_rd    = status_q[rd_addr];
  assign tgt_oob  = TGT_W'(awaited_q[idx_q]) >= TGT_W'(TASK_SLOTS);
  assign idx_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
  assign idx_nxt  = idx_last ? '0 : idx_q + IDX_W'(1);

  always_comb begin
    logic hit;
    logic miss;
    logic go_tgt;
    hit         = 1'b0;
    miss        = 1'b0;
    go_tgt      = 1'b0;
    state_d     = state_q;
    idx_d       = idx_q;
    n_d         = n_q;
    running_d   = running_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    st_we       = 1'b0;
    st_wa       = idx_q;
    st_wd       = ST_READY;
    wk_we       = 1'b0;
    wk_wa       = running_q;
    wk_wd       = now_q + ms_q;
    aw_we       = 1'b0;
    aw_wa       = running_q;
    aw_wd       = tgt_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d   = '0;
          idx_d   = running_q;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_CREATE: begin
            if (count_q < CNT_W'(TASK_SLOTS)) begin
              st_we            = 1'b1;
              st_wa            = IDX_W'(count_q);
              st_wd            = ST_READY;
              wk_we            = 1'b1;
              wk_wa            = IDX_W'(count_q);
              wk_wd            = '0;
              aw_we            = 1'b1;
              aw_wa            = IDX_W'(count_q);
              aw_wd            = '0;
              res_d.new_handle = 4'(count_q);
              count_d          = count_q + CNT_W'(1);
            end else begin
              res_d.table_full = 1'b1;
            end
            state_d = S_FINISH;
          end
          OP_EXIT: begin
            st_we   = 1'b1;
            st_wa   = running_q;
            st_wd   = ST_EXITED;
            idx_d   = idx_nxt;
            n_d     = '0;
            state_d = S_SCAN;
          end
          OP_WAIT: begin
            st_we   = 1'b1;
            st_wa   = running_q;
            st_wd   = ST_WAITING;
            aw_we   = 1'b1;
            idx_d   = idx_nxt;
            n_d     = '0;
            state_d = S_SCAN;
          end
          OP_SLEEP: begin
            st_we   = 1'b1;
            st_wa   = running_q;
            st_wd   = ST_SLEEPING;
            wk_we   = 1'b1;
            idx_d   = idx_nxt;
            n_d     = '0;
            state_d = S_SCAN;
          end
          OP_YIELD: begin
            idx_d   = idx_nxt;
            n_d     = '0;
            state_d = S_SCAN;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_SCAN: begin
        // take a ready entry, or promote a waiter whose target is gone or a sleeper past its wake time
        if (st_rd == ST_WAITING) begin
          if (tgt_oob) hit = 1'b1;
          else         go_tgt = 1'b1;
        end else if (st_rd == ST_SLEEPING) begin
          hit = wake_q[idx_q] < now_q;
        end else if (st_rd == ST_READY) begin
          hit = 1'b1;
        end
        if (go_tgt)   state_d = S_TGT;
        else if (!hit) miss = 1'b1;
      end
      S_TGT: begin
        if (st_rd == ST_EXITED) hit = 1'b1;
        else                    miss = 1'b1;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d           = res_q;
          out_d.next_task = 4'(running_q);
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (hit) begin
      st_we     = 1'b1;
      st_wa     = idx_q;
      st_wd     = ST_READY;
      running_d = idx_q;
      state_d   = S_FINISH;
    end
    if (miss) begin
      // stop after one full pass, ending at the running task
      if ((n_q + CNT_W'(1)) == count_q) begin
        res_d.none_ready = 1'b1;
        state_d          = S_FINISH;
      end else begin
        n_d     = n_q + CNT_W'(1);
        idx_d   = idx_nxt;
        state_d = S_SCAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      running_q   <= '0;
      count_q     <= CNT_W'(1);
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) status_q[i] <= ST_EXITED;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      running_q   <= running_d;
      count_q     <= count_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      if (st_we) status_q[st_wa] <= st_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_data_i.operation;
      tgt_q <= in_data_i.target_task;
      ms_q  <= TIME_BITS'(in_data_i.sleep_ms);
      now_q <= TIME_BITS'(in_data_i.now_ms);
    end
    if (wk_we) wake_q[wk_wa] <= wk_wd;
    if (aw_we) awaited_q[aw_wa] <= aw_wd;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_running_claimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(running_q) < count_q)
    else $error("running task outside claimed entries");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CNT_W'(TASK_SLOTS)))
    else $error("task count out of range");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_TGT) |-> (n_q < count_q))
    else $error("scan ran past one full pass");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(state_q == S_FINISH))
    else $error("result word appeared outside finish step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted request did not start execution");

endmodule

`default_nettype wire

// ----- dv/round_robin_task_selector_unit_tb.sv -----
// Self-checking testbench for the round-robin task selector unit.
`timescale 1ns / 1ps

module round_robin_task_selector_unit_tb;
  import rrts_pkg::*;

  localparam int SLOTS      = 12;
  localparam int DRAIN_WAIT = 40;

  // Codes outside the defined operation set.
  localparam logic [2:0] OP_UNDEF5 = 3'd5;
  localparam logic [2:0] OP_UNDEF6 = 3'd6;
  localparam logic [2:0] OP_UNDEF7 = 3'd7;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  sel_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  sel_out_t out_data_o;

  round_robin_task_selector_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Shadow task table.
  status_e     tk_status [SLOTS];
  logic [31:0] tk_wake   [SLOTS];
  logic [3:0]  tk_awaits [SLOTS];
  int unsigned tk_count;
  logic [3:0]  tk_running;

  sel_out_t    pending_picks[$];
  int          error_count;
  int          words_sent;
  int          words_checked;
  int          idle_answers;
  int          full_answers;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_hold_left;
  logic [31:0] sim_now;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("timeout: %0d words sent, %0d checked", words_sent, words_checked);
    $display("== FAIL ==");
    $finish;
  end

  // Apply one request to the shadow table and return the answer it should get.
  function automatic sel_out_t schedule_pick(sel_in_t w);
    sel_out_t    r;
    int unsigned idx;
    int unsigned n;
    logic [3:0]  t;
    bit          found;
    r     = '0;
    found = 1'b0;
    case (w.operation) inside
      OP_CREATE: begin
        if (tk_count < SLOTS) begin
          r.new_handle        = 4'(tk_count);
          tk_status[tk_count] = ST_READY;
          tk_wake[tk_count]   = '0;
          tk_awaits[tk_count] = '0;
          tk_count++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      OP_EXIT, OP_WAIT, OP_SLEEP, OP_YIELD: begin
        if (w.operation == OP_EXIT) begin
          tk_status[tk_running] = ST_EXITED;
        end else if (w.operation == OP_WAIT) begin
          tk_status[tk_running] = ST_WAITING;
          tk_awaits[tk_running] = w.target_task;
        end else if (w.operation == OP_SLEEP) begin
          tk_status[tk_running] = ST_SLEEPING;
          tk_wake[tk_running]   = w.now_ms + w.sleep_ms;
        end
        idx = tk_running;
        for (n = 0; n < tk_count && !found; n++) begin
          idx = (idx + 1) % tk_count;
          if (tk_status[idx] == ST_WAITING) begin
            t = tk_awaits[idx];
            if (t >= SLOTS || tk_status[t] == ST_EXITED) tk_status[idx] = ST_READY;
          end
          if (tk_status[idx] == ST_SLEEPING && tk_wake[idx] < w.now_ms) begin
            tk_status[idx] = ST_READY;
          end
          if (tk_status[idx] == ST_READY) found = 1'b1;
        end
        if (found) tk_running = 4'(idx);
        else r.none_ready = 1'b1;
      end
      default: ;
    endcase
    r.next_task = tk_running;
    return r;
  endfunction

  function automatic sel_in_t req(logic [2:0] op, logic [3:0] target,
                                  logic [31:0] ms, logic [31:0] now);
    sel_in_t w;
    w.operation   = op;
    w.target_task = target;
    w.sleep_ms    = ms;
    w.now_ms      = now;
    return w;
  endfunction

  // Mostly a steady clock with short sleeps; now and then noise on every field.
  function automatic sel_in_t random_request();
    sel_in_t w;
    int      pick;
    w       = '0;
    sim_now = sim_now + $urandom_range(0, 20);
    pick    = $urandom_range(0, 99);
    if (pick < 8)       w.operation = OP_CREATE;
    else if (pick < 10) w.operation = OP_EXIT;
    else if (pick < 35) w.operation = OP_WAIT;
    else if (pick < 60) w.operation = OP_SLEEP;
    else if (pick < 95) w.operation = OP_YIELD;
    else                w.operation = 3'($urandom_range(OP_UNDEF5, OP_UNDEF7));
    // Point most waits at an exited task or past the table so they resolve.
    if ($urandom_range(0, 3) == 0)      w.target_task = 4'($urandom_range(0, 15));
    else if ($urandom_range(0, 1) == 0) w.target_task = 4'd0;
    else                                w.target_task = 4'($urandom_range(SLOTS, 15));
    if ($urandom_range(0, 19) == 0) w.sleep_ms = $urandom();
    else                            w.sleep_ms = $urandom_range(0, 40);
    if ($urandom_range(0, 29) == 0) w.now_ms = $urandom();
    else                            w.now_ms = sim_now;
    return w;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on word %0d: %s got %0d, expected %0d",
             words_checked, field, got, want);
    error_count++;
  endtask

  // Offer one word after a random gap, and hold it until it is taken.
  task automatic send_word(sel_in_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    pending_picks.push_back(schedule_pick(w));
    words_sent++;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= (rx_hold_left > 0) || ($urandom_range(0, 99) < rx_idle_pct);
    if (rx_hold_left > 0) rx_hold_left--;
  end

  always @(posedge clk_i) begin
    sel_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_picks.size() == 0) begin
        $display("result word with nothing outstanding: %p", out_data_o);
        error_count++;
      end else begin
        want = pending_picks.pop_front();
        if (out_data_o.next_task != want.next_task)
          report_mismatch("next_task", out_data_o.next_task, want.next_task);
        if (out_data_o.new_handle != want.new_handle)
          report_mismatch("new_handle", out_data_o.new_handle, want.new_handle);
        if (out_data_o.none_ready != want.none_ready)
          report_mismatch("none_ready", out_data_o.none_ready, want.none_ready);
        if (out_data_o.table_full != want.table_full)
          report_mismatch("table_full", out_data_o.table_full, want.table_full);
        idle_answers += want.none_ready;
        full_answers += want.table_full;
      end
      words_checked++;
    end
  end

  // Only task 0 is claimed and it starts out exited.
  task automatic test_lone_task();
    send_word(req(OP_YIELD, 4'd0, 32'd0, 32'd0));
    send_word(req(OP_UNDEF5, 4'd3, 32'd7, 32'd9));
    send_word(req(OP_UNDEF6, 4'd0, 32'd0, 32'd0));
    send_word(req(OP_UNDEF7, 4'hF, '1, '1));
    // Waiting on itself must never make the task ready.
    send_word(req(OP_WAIT, 4'd0, 32'd0, 32'd10));
    send_word(req(OP_WAIT, 4'hF, 32'd0, 32'd10));
    // Wake time wraps below now.
    send_word(req(OP_SLEEP, 4'd0, '1, '1));
    send_word(req(OP_SLEEP, 4'd0, 32'd0, 32'd0));
    send_word(req(OP_YIELD, 4'd0, 32'd0, 32'd1));
    send_word(req(OP_EXIT, 4'd0, 32'd0, 32'd2));
  endtask

  task automatic test_fill_table();
    repeat (SLOTS) send_word(req(OP_CREATE, 4'd0, 32'd0, 32'd3));
  endtask

  task automatic test_first_scans();
    send_word(req(OP_YIELD, 4'd0, 32'd0, 32'd4));
    send_word(req(OP_WAIT, 4'd12, 32'd0, 32'd5));
    send_word(req(OP_EXIT, 4'hF, '1, '1));
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_word(random_request());
  endtask

  // Hold the output long enough for the unit to fill and stall its input.
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(posedge clk_i);
    rx_hold_left = 250;
    repeat (12) send_word(random_request());
  endtask

  task automatic test_drain_pause();
    tx_idle_pct = 10;
    rx_idle_pct = 30;
    repeat (15) send_word(random_request());
    // Drop the offer before pausing so the last word is not taken twice.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (15) send_word(random_request());
  endtask

  initial begin
    int n;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    error_count  = 0;
    words_sent   = 0;
    words_checked = 0;
    idle_answers = 0;
    full_answers = 0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_left = 0;
    sim_now      = 32'd200;
    for (n = 0; n < SLOTS; n++) begin
      tk_status[n] = ST_EXITED;
      tk_wake[n]   = '0;
      tk_awaits[n] = '0;
    end
    tk_count   = 1;
    tk_running = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_lone_task();
    test_fill_table();
    test_first_scans();
    test_random_traffic(23, 63, 300);
    test_output_backpressure();
    test_random_traffic(63, 23, 290);
    test_drain_pause();
    test_random_traffic(0, 0, 300);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_picks.size() != 0) begin
      $display("%0d expected results never arrived", pending_picks.size());
      error_count++;
    end
    $display("covered %0d requests: lone-task cases, table fill, random scheduling",
             words_sent);
    $display("results checked %0d (none ready %0d, table full %0d), mismatches %0d",
             words_checked, idle_answers, full_answers, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
